[hdl/oat_pkg.sv]
// ---------------------------------------------------------------------------
// oat_pkg
// Shared types and constants of the outstanding address tracker: table
// geometry, command and status codes, item structs and control/status bundles.
// ---------------------------------------------------------------------------
package oat_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int ADDRESS_WIDTH = 32;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;

    typedef enum logic [1:0] {
        CMD_RECORD  = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_REPORT  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STS_RECORDED  = 3'd0,
        STS_FULL      = 3'd1,
        STS_RELEASED  = 3'd2,
        STS_UNTRACKED = 3'd3,
        STS_NULL      = 3'd4,
        STS_LEAK      = 3'd5,
        STS_NO_LEAKS  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_SHIFT,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [ADDRESS_WIDTH-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic [ADDRESS_WIDTH-1:0] entry_address;
        logic [CNT_W-1:0]         held_count;
        logic                     last;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    seek;
        logic    wr_rec;
        logic    wr_shift;
        logic    dec;
        logic    emit;
        t_status emit_status;
        logic    emit_rdata;
        logic    emit_last;
    } t_dp_ctrl;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       addr_zero;
        logic       full;
        logic       count_zero;
        logic       rd_end;
        logic       rd_valid;
        logic       match;
        logic       rd_last;
    } t_dp_stat;

endpackage

[hdl/oat_datapath.sv]
// ---------------------------------------------------------------------------
// oat_datapath
// Address table memory, entry count, read pointer and result register.
// ---------------------------------------------------------------------------
module oat_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oat_pkg::t_in_item i_item,
    input  oat_pkg::t_dp_ctrl i_ctrl,
    output oat_pkg::t_dp_stat o_stat,
    output logic              o_strobe,
    output oat_pkg::t_out_item o_result
);

    logic [oat_pkg::ADDRESS_WIDTH-1:0] r_mem [oat_pkg::TABLE_DEPTH];

    logic [oat_pkg::CNT_W-1:0]         r_count;
    logic [oat_pkg::CNT_W-1:0]         n_count;
    logic [oat_pkg::CNT_W-1:0]         r_rd_idx;
    logic                              r_rd_valid;
    logic [oat_pkg::IDX_W-1:0]         r_rdata_idx;
    logic [oat_pkg::ADDRESS_WIDTH-1:0] r_rdata;
    logic [1:0]                        r_cmd;
    logic [oat_pkg::ADDRESS_WIDTH-1:0] r_addr;
    logic                              r_strobe;
    oat_pkg::t_out_item                r_result;

    always_comb begin
        n_count = r_count;
        if (i_ctrl.wr_rec) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_idx   <= '0;
            r_rd_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rd_valid <= i_ctrl.rd_en;
            r_strobe   <= i_ctrl.emit;
            if (i_ctrl.load) begin
                r_rd_idx <= '0;
            end else if (i_ctrl.seek) begin
                r_rd_idx <= {1'b0, r_rdata_idx} + 1'b1;
            end else if (i_ctrl.rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_rec) begin
            r_mem[r_count[oat_pkg::IDX_W-1:0]] <= r_addr;
        end else if (i_ctrl.wr_shift) begin
            r_mem[r_rdata_idx - 1'b1] <= r_rdata;
        end
        if (i_ctrl.rd_en) begin
            r_rdata     <= r_mem[r_rd_idx[oat_pkg::IDX_W-1:0]];
            r_rdata_idx <= r_rd_idx[oat_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_item.cmd;
            r_addr <= i_item.address;
        end
        if (i_ctrl.emit) begin
            r_result.status        <= i_ctrl.emit_status;
            r_result.entry_address <= i_ctrl.emit_rdata ? r_rdata : r_addr;
            r_result.held_count    <= n_count;
            r_result.last          <= i_ctrl.emit_last;
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.addr_zero  = (r_addr == '0);
        o_stat.full       = (r_count == oat_pkg::CNT_W'(oat_pkg::TABLE_DEPTH));
        o_stat.count_zero = (r_count == '0);
        o_stat.rd_end     = (r_rd_idx == r_count);
        o_stat.rd_valid   = r_rd_valid;
        o_stat.match      = (r_rdata == r_addr);
        o_stat.rd_last    = ({1'b0, r_rdata_idx} == (r_count - 1'b1));
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

[hdl/oat_ctrl.sv]
// ---------------------------------------------------------------------------
// oat_ctrl
// Command sequencer: decodes an item and steps the datapath through search,
// compaction and report walks.
// ---------------------------------------------------------------------------
module oat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  oat_pkg::t_dp_stat i_stat,
    output oat_pkg::t_dp_ctrl o_ctrl,
    output logic              busy
);

    oat_pkg::t_state r_state;
    oat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        o_ctrl             = '0;
        o_ctrl.emit_status = oat_pkg::STS_NULL;
        o_ctrl.emit_last   = 1'b1;
        busy               = (r_state != oat_pkg::ST_IDLE);

        case (r_state)
            oat_pkg::ST_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = oat_pkg::ST_DECODE;
                end
            end

            oat_pkg::ST_DECODE: begin
                n_state = oat_pkg::ST_IDLE;
                case (i_stat.cmd)
                    oat_pkg::CMD_RECORD: begin
                        o_ctrl.emit = 1'b1;
                        if (i_stat.addr_zero) begin
                            o_ctrl.emit_status = oat_pkg::STS_NULL;
                        end else if (i_stat.full) begin
                            o_ctrl.emit_status = oat_pkg::STS_FULL;
                        end else begin
                            o_ctrl.wr_rec      = 1'b1;
                            o_ctrl.emit_status = oat_pkg::STS_RECORDED;
                        end
                    end
                    oat_pkg::CMD_RELEASE: begin
                        if (i_stat.addr_zero) begin
                            o_ctrl.emit        = 1'b1;
                            o_ctrl.emit_status = oat_pkg::STS_NULL;
                        end else begin
                            n_state = oat_pkg::ST_SEARCH;
                        end
                    end
                    oat_pkg::CMD_REPORT: begin
                        if (i_stat.count_zero) begin
                            o_ctrl.emit        = 1'b1;
                            o_ctrl.emit_status = oat_pkg::STS_NO_LEAKS;
                        end else begin
                            n_state = oat_pkg::ST_REPORT;
                        end
                    end
                    default: begin
                        n_state = oat_pkg::ST_IDLE;
                    end
                endcase
            end

            oat_pkg::ST_SEARCH: begin
                if (i_stat.rd_valid && i_stat.match) begin
                    // rewind the read pointer to the entry after the hit
                    o_ctrl.seek = 1'b1;
                    n_state     = oat_pkg::ST_SHIFT;
                end else if (i_stat.rd_end && !i_stat.rd_valid) begin
                    o_ctrl.emit        = 1'b1;
                    o_ctrl.emit_status = oat_pkg::STS_UNTRACKED;
                    n_state            = oat_pkg::ST_IDLE;
                end else if (!i_stat.rd_end) begin
                    o_ctrl.rd_en = 1'b1;
                end
            end

            oat_pkg::ST_SHIFT: begin
                o_ctrl.rd_en    = !i_stat.rd_end;
                o_ctrl.wr_shift = i_stat.rd_valid;
                if (i_stat.rd_end && !i_stat.rd_valid) begin
                    o_ctrl.dec         = 1'b1;
                    o_ctrl.emit        = 1'b1;
                    o_ctrl.emit_status = oat_pkg::STS_RELEASED;
                    n_state            = oat_pkg::ST_IDLE;
                end
            end

            oat_pkg::ST_REPORT: begin
                o_ctrl.rd_en = !i_stat.rd_end;
                if (i_stat.rd_valid) begin
                    o_ctrl.emit        = 1'b1;
                    o_ctrl.emit_status = oat_pkg::STS_LEAK;
                    o_ctrl.emit_rdata  = 1'b1;
                    o_ctrl.emit_last   = i_stat.rd_last;
                    if (i_stat.rd_last) begin
                        n_state = oat_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = oat_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/outstanding_address_tracker.sv]
// ---------------------------------------------------------------------------
// outstanding_address_tracker
// Ordered table of outstanding nonzero addresses with record, release and
// report commands; release removes the oldest match and closes the gap.
// ---------------------------------------------------------------------------
// Sequence: record, null and empty-report results come straight from decode;
//   release searches the table from the oldest entry, then shifts the later
//   entries down, one table entry a cycle through one read port; report
//   strobes one held entry a cycle, oldest first, and marks the last.
// Throughput: one item at a time; busy drops as the last result is strobed.
// Reset: synchronous, active low; empties the table (count to zero), no sweep.
// ---------------------------------------------------------------------------
module outstanding_address_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  oat_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output oat_pkg::t_out_item o_result
);

    // controller <-> datapath bundles
    oat_pkg::t_dp_ctrl w_ctrl;
    oat_pkg::t_dp_stat w_stat;

    // Sequence each item: decode, then walk the table when the command needs it
    oat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .busy    (busy)
    );

    // Hold the table, the count and the registered result; results are
    // strobed for one cycle and cannot be held off
    oat_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
